// ----- rtl/mseu_pkg.sv -----
package mseu_pkg;

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,  CMD_AND  = 5'd1,  CMD_DIV  = 5'd2,  CMD_JR   = 5'd3,
    CMD_MFHI = 5'd4,  CMD_MFLO = 5'd5,  CMD_MULT = 5'd6,  CMD_NOR  = 5'd7,
    CMD_XOR  = 5'd8,  CMD_OR   = 5'd9,  CMD_SLT  = 5'd10, CMD_SLL  = 5'd11,
    CMD_SRL  = 5'd12, CMD_SUB  = 5'd13, CMD_ADDI = 5'd14, CMD_ANDI = 5'd15,
    CMD_BEQ  = 5'd16, CMD_BNE  = 5'd17, CMD_LW   = 5'd18, CMD_LUI  = 5'd19,
    CMD_ORI  = 5'd20, CMD_SLTI = 5'd21, CMD_SW   = 5'd22, CMD_J    = 5'd23,
    CMD_JAL  = 5'd24
  } cmd_e;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_RD   = 2'd1;
  localparam logic [1:0] TGT_RT   = 2'd2;
  localparam logic [1:0] TGT_LINK = 2'd3;

  localparam logic [1:0] MOP_NONE  = 2'd0;
  localparam logic [1:0] MOP_LOAD  = 2'd1;
  localparam logic [1:0] MOP_STORE = 2'd2;

  localparam int unsigned LuiShift = 16;

  typedef struct packed {
    logic [4:0]  command;
    logic [31:0] source_a;
    logic [31:0] source_b;
    logic [4:0]  shift_amount;
    logic [31:0] imm_value;
    logic [31:0] jump_target;
    logic [31:0] current_ip;
  } item_t;

  typedef struct packed {
    logic [31:0] write_value;
    logic [1:0]  write_target;
    logic        ip_changed;
    logic [31:0] new_ip;
    logic [1:0]  mem_op;
    logic [31:0] mem_address;
    logic [31:0] store_data;
    logic        divide_by_zero;
  } result_t;

  // front-end classification
  typedef struct packed {
    logic  is_mul;
    logic  is_div;
    item_t item;
  } work_t;

endpackage

// ----- rtl/mseu_front.sv -----
module mseu_front import mseu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_ready_i,
  output work_t q_work_o
);

  // two-entry queue
  work_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  work_t      w;

  always_comb begin
    w.item   = in_item_i;
    w.is_mul = (in_item_i.command == CMD_MULT);
    w.is_div = (in_item_i.command == CMD_DIV);
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_work_o   = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= w;
  end

endmodule

// ----- rtl/mseu_muldiv.sv -----
module mseu_muldiv import mseu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_div_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] hi_o,
  output logic [31:0] lo_o
);

  // mult: 4 partial products 16x16 accumulated in turn; div: restoring, 1 bit/cycle
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  st_q;
  logic [4:0]  cnt_q;
  logic [31:0] a_q, b_q;
  logic [63:0] acc_q;
  logic [31:0] rem_q, quo_q;
  logic [15:0] pa, pb;
  logic [31:0] pp;
  logic [33:0] trial;
  logic [32:0] rsh;

  always_comb begin
    pa = cnt_q[0] ? a_q[31:16] : a_q[15:0];
    pb = cnt_q[1] ? b_q[31:16] : b_q[15:0];
    pp = pa * pb;
    rsh = {rem_q, quo_q[31]};
    trial = {1'b0, rsh} - {2'b00, b_q};
  end

  assign done_o = (st_q == S_DONE);
  assign hi_o = is_div_i ? rem_q : acc_q[63:32];
  assign lo_o = is_div_i ? quo_q : acc_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
    end else begin
      unique case (st_q)
        S_IDLE: if (start_i) begin
          cnt_q <= '0;
          if (is_div_i && b_i == '0) st_q <= S_DONE;
          else st_q <= is_div_i ? S_DIV : S_MUL;
        end
        S_MUL: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd3) st_q <= S_DONE;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) st_q <= S_DONE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
      if (is_div_i && b_i == '0) begin
        quo_q <= '1;
        rem_q <= a_i;
      end else begin
        quo_q <= a_i;
        rem_q <= '0;
      end
    end else if (st_q == S_MUL) begin
      acc_q <= acc_q + ({32'd0, pp} << {cnt_q[1] , 4'd0} << {cnt_q[0], 4'd0});
    end else if (st_q == S_DIV) begin
      if (!trial[33]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rsh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/mseu_back.sv -----
module mseu_back import mseu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  output logic    q_ready_o,
  input  work_t   q_work_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  logic [31:0] hi_q, lo_q;
  logic        busy_q;
  logic        out_valid_q;
  result_t     out_q;
  result_t     r;
  logic        slot_free, md_item, md_start, md_done;
  logic [31:0] md_hi, md_lo;
  item_t       it;

  assign it = q_work_i.item;
  assign md_item = q_work_i.is_mul || q_work_i.is_div;
  assign slot_free = !out_valid_q || out_ready_i;
  assign md_start = q_valid_i && md_item && !busy_q && slot_free;
  assign q_ready_o = slot_free && (md_item ? md_done : !busy_q);

  mseu_muldiv u_muldiv (
    .clk_i,
    .rst_ni,
    .start_i (md_start),
    .is_div_i(q_work_i.is_div),
    .a_i     (it.source_a),
    .b_i     (it.source_b),
    .done_o  (md_done),
    .hi_o    (md_hi),
    .lo_o    (md_lo)
  );

  always_comb begin
    r = '0;
    unique case (it.command)
      CMD_ADD:  begin r.write_value = it.source_a + it.source_b; r.write_target = TGT_RD; end
      CMD_AND:  begin r.write_value = it.source_a & it.source_b; r.write_target = TGT_RD; end
      CMD_DIV:  r.divide_by_zero = (it.source_b == '0);
      CMD_JR:   begin r.ip_changed = 1'b1; r.new_ip = it.source_a; end
      CMD_MFHI: begin r.write_value = hi_q; r.write_target = TGT_RD; end
      CMD_MFLO: begin r.write_value = lo_q; r.write_target = TGT_RD; end
      CMD_MULT: ;
      CMD_NOR:  begin r.write_value = ~(it.source_a | it.source_b); r.write_target = TGT_RD; end
      CMD_XOR:  begin r.write_value = it.source_a ^ it.source_b; r.write_target = TGT_RD; end
      CMD_OR:   begin r.write_value = it.source_a | it.source_b; r.write_target = TGT_RD; end
      CMD_SLT:  begin
        r.write_value = {31'd0, it.source_a < it.source_b}; r.write_target = TGT_RD;
      end
      CMD_SLL:  begin r.write_value = it.source_a << it.shift_amount; r.write_target = TGT_RD; end
      CMD_SRL:  begin r.write_value = it.source_a >> it.shift_amount; r.write_target = TGT_RD; end
      CMD_SUB:  begin r.write_value = it.source_a - it.source_b; r.write_target = TGT_RD; end
      CMD_ADDI: begin r.write_value = it.source_a + it.imm_value; r.write_target = TGT_RT; end
      CMD_ANDI: begin r.write_value = it.source_a & it.imm_value; r.write_target = TGT_RT; end
      CMD_BEQ:  if (it.source_a == it.source_b) begin
        r.ip_changed = 1'b1; r.new_ip = it.imm_value;
      end
      CMD_BNE:  if (it.source_a != it.source_b) begin
        r.ip_changed = 1'b1; r.new_ip = it.imm_value;
      end
      CMD_LW:   begin
        r.write_target = TGT_RT; r.mem_op = MOP_LOAD;
        r.mem_address = it.source_a + it.imm_value;
      end
      CMD_LUI:  begin
        r.write_value = it.imm_value << LuiShift; r.write_target = TGT_RT;
      end
      CMD_ORI:  begin r.write_value = it.source_a | it.imm_value; r.write_target = TGT_RT; end
      CMD_SLTI: begin
        r.write_value = {31'd0, it.source_a < it.imm_value}; r.write_target = TGT_RT;
      end
      CMD_SW:   begin
        r.mem_op = MOP_STORE; r.mem_address = it.source_a + it.imm_value;
        r.store_data = it.source_b;
      end
      CMD_J:    begin r.ip_changed = 1'b1; r.new_ip = it.jump_target; end
      CMD_JAL:  begin
        r.write_value = it.current_ip + 32'd1; r.write_target = TGT_LINK;
        r.ip_changed = 1'b1; r.new_ip = it.jump_target;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q        <= '0;
      lo_q        <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (md_start) busy_q <= 1'b1;
      else if (md_done) busy_q <= 1'b0;
      if (q_valid_i && q_ready_o) begin
        out_valid_q <= 1'b1;
        if (md_item) begin
          hi_q <= md_hi;
          lo_q <= md_lo;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) out_q <= r;
  end

endmodule

// ----- rtl/mips_subset_execute_unit.sv -----
// ALU, branch and memory commands go from input to output through the queue and output register.
// MULT forms four 16x16 partial products; DIV divides one quotient bit a cycle, skipping the
// division steps when the divisor is zero. Throughput is one word a cycle while m_axis_tready is
// high, except behind MULT/DIV, which hold the back end until the shared multiply/divide unit
// finishes. Reset (rst_ni low, asynchronous) empties the queue and output and clears HI and LO.
module mips_subset_execute_unit import mseu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[4:0], source_a[36:5], source_b[68:37], shift_amount[73:69],
  // imm_value[105:74], jump_target[137:106], current_ip[169:138], zero fill
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // write_value[31:0], write_target[33:32], ip_changed[34], new_ip[66:35],
  // mem_op[68:67], mem_address[100:69], store_data[132:101], divide_by_zero[133], zero fill
  output logic [135:0] m_axis_tdata
);

  item_t   in_item;
  work_t   q_work;
  logic    q_valid, q_ready;
  result_t res;

  always_comb begin
    in_item.command      = s_axis_tdata[4:0];
    in_item.source_a     = s_axis_tdata[36:5];
    in_item.source_b     = s_axis_tdata[68:37];
    in_item.shift_amount = s_axis_tdata[73:69];
    in_item.imm_value    = s_axis_tdata[105:74];
    in_item.jump_target  = s_axis_tdata[137:106];
    in_item.current_ip   = s_axis_tdata[169:138];
  end

  mseu_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_item_i (in_item),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_work_o  (q_work)
  );

  mseu_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_work_i   (q_work),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (res)
  );

  assign m_axis_tdata = {2'b00, res.divide_by_zero, res.store_data, res.mem_address,
                         res.mem_op, res.new_ip, res.ip_changed, res.write_target,
                         res.write_value};

endmodule
